[hw/rtl/rm2d_pkg.sv]
// Shared types, constants and helper functions for the 2-D range-max segment tree.
`default_nettype none

package rm2d_pkg;

  // Default geometry and value width
  localparam int ROWS_DEF        = 16;
  localparam int COLS_DEF        = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the stream items
  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int END_W      = 5;
  localparam int IN_VAL_W   = 32;
  localparam int OUT_W      = 32;
  localparam int IN_DATA_W  = 56;  // 50 field bits padded to whole bytes
  localparam int OUT_DATA_W = 32;

  // Request kinds carried on tuser
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Most negative 32-bit result, also the answer for an empty rectangle
  localparam logic [OUT_W-1:0] OUT_EMPTY_VAL = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_U_LEAF,
    S_U_CRD,
    S_U_CWR,
    S_U_RRD0,
    S_U_RWAIT,
    S_U_RRD,
    S_U_RWR,
    S_Q_OUTER,
    S_Q_INNER,
    S_Q_DRAIN,
    S_Q_FIN
  } state_t;

  // Row-bound phase of the outer query walk
  typedef enum logic [1:0] {
    QP_LO,
    QP_HI,
    QP_SHIFT
  } qphase_t;

  // Finished-query handoff from the sequencer to the output stage
  typedef struct packed {
    logic vld;
    logic empty;
  } fin_t;

  // Smallest power of two not below x
  function automatic int pow2up(input int x);
    int p;
    p = 1;
    while (p < x) p = p * 2;
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rm2d_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module rm2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rm2d_seq.sv]
// Sequencer and shared max unit: clear pass, point update walk, rectangle query walk.
`default_nettype none

module rm2d_seq
  import rm2d_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int COLS        = COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int TH  = pow2up(ROWS),
  localparam int TW  = pow2up(COLS),
  localparam int HW  = $clog2(TH) + 1,
  localparam int WBW = $clog2(TW) + 1,
  localparam int AW  = HW + WBW
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        ready,
  input  wire logic                   req_type,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [COL_W-1:0]       col,
  input  wire logic [END_W-1:0]       row_end,
  input  wire logic [END_W-1:0]       col_end,
  input  wire logic [IN_VAL_W-1:0]    value,
  input  wire logic                   out_free,
  output fin_t                        fin,
  output logic [OUT_W-1:0]            max_value,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [VALUE_WIDTH-1:0]      ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  wire logic [VALUE_WIDTH-1:0] ram_rdata
);

  localparam int VW  = VALUE_WIDTH;
  localparam int SW  = (VW > OUT_W) ? VW : OUT_W;
  localparam int MXD = (ROWS > COLS) ? ROWS : COLS;
  localparam int XW0 = $clog2(MXD + 1);
  localparam int XW  = (XW0 > END_W) ? XW0 : END_W;

  localparam logic signed [VW-1:0] IDENT   = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_MIN = SW'(signed'(32'h8000_0000));
  localparam logic signed [SW-1:0] SAT_MAX = SW'(signed'(32'h7FFF_FFFF));

  function automatic logic [AW-1:0] addr_of(input logic [HW-1:0] h, input logic [WBW-1:0] w);
    return {h, w};
  endfunction

  state_t                state_r, state_nxt;
  qphase_t               qph_r, qph_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  empty_r, empty_nxt;
  logic                  iside_r, iside_nxt;
  logic [HW-1:0]         lh_r, lh_nxt;
  logic [WBW-1:0]        w_r, w_nxt;
  logic [HW-1:0]         ci_r, ci_nxt;
  logic [HW-1:0]         rh_r, rh_nxt;
  logic [WBW-1:0]        cj_r, cj_nxt;
  logic signed [VW-1:0]  cur_r, cur_nxt;
  logic signed [VW-1:0]  acc_r, acc_nxt;
  logic [HW:0]           qh1_r, qh1_nxt, qh2_r, qh2_nxt;
  logic [WBW:0]          qw1_r, qw1_nxt, qw2_r, qw2_nxt;
  logic [WBW:0]          wc1_r, wc1_nxt, wc2_r, wc2_nxt;
  logic [HW-1:0]         hs_r, hs_nxt;

  logic                  q_rd;
  logic [HW:0]           qh2_dec;
  logic [WBW:0]          wc2_dec;
  logic signed [VW-1:0]  mx_a, mx;
  logic signed [IN_VAL_W-1:0] vin;
  logic signed [SW-1:0]  vext, aext, sat;
  logic [XW-1:0]         re_c, ce_c;
  logic                  q_empty, u_out;

  assign qh2_dec = qh2_r - (HW+1)'(1);
  assign wc2_dec = wc2_r - (WBW+1)'(1);

  // Shared compare unit: query accumulator while a query read lands, else update carry
  assign mx_a = rd_pend_r ? acc_r : cur_r;
  assign mx   = (mx_a >= $signed(ram_rdata)) ? mx_a : $signed(ram_rdata);

  // Wrap or sign-extend the input value to the stored width
  assign vin  = signed'(value);
  assign vext = SW'(vin);

  // Clamp query bounds to the grid and test for an empty rectangle
  assign re_c    = (XW'(row_end) > XW'(ROWS)) ? XW'(ROWS) : XW'(row_end);
  assign ce_c    = (XW'(col_end) > XW'(COLS)) ? XW'(COLS) : XW'(col_end);
  assign q_empty = (XW'(row) >= re_c) || (XW'(col) >= ce_c);
  assign u_out   = (XW'(row) >= XW'(ROWS)) || (XW'(col) >= XW'(COLS));

  // Saturate the accumulator to the 32-bit result range
  assign aext      = SW'(acc_r);
  assign sat       = (aext < SAT_MIN) ? SAT_MIN : ((aext > SAT_MAX) ? SAT_MAX : aext);
  assign max_value = empty_r ? OUT_EMPTY_VAL : sat[OUT_W-1:0];

  assign ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qph_r   <= qph_nxt;
    empty_r <= empty_nxt;
    iside_r <= iside_nxt;
    lh_r    <= lh_nxt;
    w_r     <= w_nxt;
    ci_r    <= ci_nxt;
    rh_r    <= rh_nxt;
    cj_r    <= cj_nxt;
    cur_r   <= cur_nxt;
    acc_r   <= acc_nxt;
    qh1_r   <= qh1_nxt;
    qh2_r   <= qh2_nxt;
    qw1_r   <= qw1_nxt;
    qw2_r   <= qw2_nxt;
    wc1_r   <= wc1_nxt;
    wc2_r   <= wc2_nxt;
    hs_r    <= hs_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    qph_nxt   = qph_r;
    clr_nxt   = clr_r;
    empty_nxt = empty_r;
    iside_nxt = iside_r;
    lh_nxt    = lh_r;
    w_nxt     = w_r;
    ci_nxt    = ci_r;
    rh_nxt    = rh_r;
    cj_nxt    = cj_r;
    cur_nxt   = cur_r;
    acc_nxt   = rd_pend_r ? mx : acc_r;
    qh1_nxt   = qh1_r;
    qh2_nxt   = qh2_r;
    qw1_nxt   = qw1_r;
    qw2_nxt   = qw2_r;
    wc1_nxt   = wc1_r;
    wc2_nxt   = wc2_r;
    hs_nxt    = hs_r;
    q_rd      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    fin.vld   = 1'b0;
    fin.empty = empty_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = IDENT;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_UPDATE) begin
            if (!u_out) begin
              lh_nxt    = HW'(row) + HW'(TH);
              w_nxt     = WBW'(col) + WBW'(TW);
              cur_nxt   = vext[VW-1:0];
              state_nxt = S_U_LEAF;
            end
          end else begin
            acc_nxt   = IDENT;
            empty_nxt = q_empty;
            if (q_empty) begin
              state_nxt = S_Q_FIN;
            end else begin
              qh1_nxt   = (HW+1)'(row) + (HW+1)'(TH);
              qh2_nxt   = (HW+1)'(re_c) + (HW+1)'(TH);
              qw1_nxt   = (WBW+1)'(col) + (WBW+1)'(TW);
              qw2_nxt   = (WBW+1)'(ce_c) + (WBW+1)'(TW);
              qph_nxt   = QP_LO;
              state_nxt = S_Q_OUTER;
            end
          end
        end
      end

      // Update: write the leaf, then climb its column of row nodes
      S_U_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(lh_r, w_r);
        ram_wdata = cur_r;
        ci_nxt    = lh_r;
        rh_nxt    = lh_r;
        if ((lh_r >> 1) != '0) begin
          state_nxt = S_U_CRD;
        end else if ((w_r >> 1) != '0) begin
          state_nxt = S_U_RRD0;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_U_CRD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(ci_r ^ HW'(1), w_r);
        state_nxt = S_U_CWR;
      end

      S_U_CWR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(ci_r >> 1, w_r);
        ram_wdata = mx;
        cur_nxt   = mx;
        ci_nxt    = ci_r >> 1;
        if ((ci_r >> 2) != '0) begin
          state_nxt = S_U_CRD;
        end else if ((w_r >> 1) != '0) begin
          state_nxt = S_U_RRD0;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Update: for each affected tree row, climb the column tree
      S_U_RRD0: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(rh_r, w_r);
        cj_nxt    = w_r;
        state_nxt = S_U_RWAIT;
      end

      S_U_RWAIT: begin
        cur_nxt   = $signed(ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = addr_of(rh_r, cj_r ^ WBW'(1));
        state_nxt = S_U_RWR;
      end

      S_U_RRD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(rh_r, cj_r ^ WBW'(1));
        state_nxt = S_U_RWR;
      end

      S_U_RWR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(rh_r, cj_r >> 1);
        ram_wdata = mx;
        cur_nxt   = mx;
        cj_nxt    = cj_r >> 1;
        if ((cj_r >> 2) != '0) begin
          state_nxt = S_U_RRD;
        end else begin
          rh_nxt = rh_r >> 1;
          if ((rh_r >> 1) != '0) begin
            state_nxt = S_U_RRD0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Query: bottom-up walk over tree rows
      S_Q_OUTER: begin
        case (qph_r)
          QP_LO: begin
            if (qh1_r >= qh2_r) begin
              state_nxt = S_Q_DRAIN;
            end else if (qh1_r[0]) begin
              hs_nxt    = qh1_r[HW-1:0];
              qh1_nxt   = qh1_r + (HW+1)'(1);
              wc1_nxt   = qw1_r;
              wc2_nxt   = qw2_r;
              iside_nxt = 1'b0;
              qph_nxt   = QP_HI;
              state_nxt = S_Q_INNER;
            end else begin
              qph_nxt = QP_HI;
            end
          end
          QP_HI: begin
            if (qh2_r[0]) begin
              hs_nxt    = qh2_dec[HW-1:0];
              qh2_nxt   = qh2_dec;
              wc1_nxt   = qw1_r;
              wc2_nxt   = qw2_r;
              iside_nxt = 1'b0;
              qph_nxt   = QP_SHIFT;
              state_nxt = S_Q_INNER;
            end else begin
              qh1_nxt = qh1_r >> 1;
              qh2_nxt = qh2_r >> 1;
              qph_nxt = QP_LO;
            end
          end
          QP_SHIFT: begin
            qh1_nxt = qh1_r >> 1;
            qh2_nxt = qh2_r >> 1;
            qph_nxt = QP_LO;
          end
          default: begin
            qph_nxt = QP_LO;
          end
        endcase
      end

      // Query: bottom-up walk over column nodes of one tree row, at most one read a cycle
      S_Q_INNER: begin
        if (!iside_r) begin
          if (wc1_r >= wc2_r) begin
            state_nxt = S_Q_OUTER;
          end else begin
            if (wc1_r[0]) begin
              ram_re    = 1'b1;
              ram_raddr = addr_of(hs_r, wc1_r[WBW-1:0]);
              q_rd      = 1'b1;
              wc1_nxt   = wc1_r + (WBW+1)'(1);
            end
            iside_nxt = 1'b1;
          end
        end else begin
          if (wc2_r[0]) begin
            ram_re    = 1'b1;
            ram_raddr = addr_of(hs_r, wc2_dec[WBW-1:0]);
            q_rd      = 1'b1;
          end
          wc1_nxt   = wc1_r >> 1;
          wc2_nxt   = wc2_r >> 1;
          iside_nxt = 1'b0;
        end
      end

      // Let the last read land in the accumulator
      S_Q_DRAIN: begin
        state_nxt = S_Q_FIN;
      end

      // Hold until the output register can take the result
      S_Q_FIN: begin
        fin.vld = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_pend_nxt = q_rd;

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM read and write issued in the same cycle");

  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    fin.vld |-> !rd_pend_r)
    else $error("query finished with a read still in flight");

  a_acc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> (acc_r >= $past(acc_r)))
    else $error("query accumulator decreased");

endmodule

`default_nettype wire

[hw/rtl/range_max_2d_segment_tree.sv]
// Point update: write the leaf, climb its column of row nodes, then climb the column
// tree of every affected tree row, one read or one write of the node RAM per step.
// Query: bottom-up walk over the row levels, with a column walk in each visited tree
// row, then drain and finish; an empty rectangle goes straight to the finish state.
// One item at a time, in_tready low while it is worked.
// Reset: synchronous, active low; a clearing pass then writes the identity into all
// 4*TH*TW nodes with in_tready low.
`default_nettype none

module range_max_2d_segment_tree
  import rm2d_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int COLS        = COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // row, col, row_end, col_end, value, zero pad
  input  wire logic                  in_tuser,   // req_type
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // max_value
  output logic                       out_tuser   // range_empty
);

  localparam int TH    = pow2up(ROWS);
  localparam int TW    = pow2up(COLS);
  localparam int HW    = $clog2(TH) + 1;
  localparam int WBW   = $clog2(TW) + 1;
  localparam int AW    = HW + WBW;
  localparam int DEPTH = 4 * TH * TW;

  // Unpack the request fields from tdata
  logic [ROW_W-1:0]    f_row;
  logic [COL_W-1:0]    f_col;
  logic [END_W-1:0]    f_row_end;
  logic [END_W-1:0]    f_col_end;
  logic [IN_VAL_W-1:0] f_value;

  assign f_row     = in_tdata[3:0];
  assign f_col     = in_tdata[7:4];
  assign f_row_end = in_tdata[12:8];
  assign f_col_end = in_tdata[17:13];
  assign f_value   = in_tdata[49:18];

  logic                   start;
  logic                   seq_ready;
  logic                   out_free;
  fin_t                   fin;
  logic [OUT_W-1:0]       seq_max;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  // Output register state
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic                   out_empty_r, out_empty_nxt;

  assign in_tready = seq_ready;
  assign start     = in_tvalid && seq_ready;

  // The output register can take a new result when empty or being drained now
  assign out_free = !out_valid_r || out_tready;

  rm2d_seq #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .ready     (seq_ready),
    .req_type  (in_tuser),
    .row       (f_row),
    .col       (f_col),
    .row_end   (f_row_end),
    .col_end   (f_col_end),
    .value     (f_value),
    .out_free  (out_free),
    .fin       (fin),
    .max_value (seq_max),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Node store, row-major over 2*TH tree rows by 2*TW tree columns
  rm2d_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load a finished result, or drop the held one once it is transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    if (fin.vld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = seq_max;
      out_empty_nxt = fin.empty;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_empty_r;

endmodule

`default_nettype wire

[test/rm2d_query_checker.sv]
// Scoreboard for the 2-D range-max tree: mirrors the grid, predicts query results, compares.
module rm2d_query_checker
  import rm2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    error_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAD_W = IN_DATA_W - ROW_W - COL_W - 2 * END_W - IN_VAL_W;

  // Request fields, lowest bits last
  typedef struct packed {
    logic [PAD_W-1:0]           pad;
    logic signed [IN_VAL_W-1:0] value;
    logic [END_W-1:0]           col_end;
    logic [END_W-1:0]           row_end;
    logic [COL_W-1:0]           col;
    logic [ROW_W-1:0]           row;
  } rect_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] max_value;
    logic             range_empty;
  } rect_result_t;

  // Leaf values only: every tree node is the max of its leaves, so the plain grid suffices
  logic signed [IN_VAL_W-1:0] cell_grid [ROWS_DEF][COLS_DEF];
  rect_result_t               expected_maxima [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic rect_result_t predict_rect_max(input rect_req_t rq);
    rect_result_t               res;
    logic signed [IN_VAL_W-1:0] best;
    int                         r_hi;
    int                         c_hi;
    r_hi = (rq.row_end > ROWS_DEF) ? ROWS_DEF : int'(rq.row_end);
    c_hi = (rq.col_end > COLS_DEF) ? COLS_DEF : int'(rq.col_end);
    best = OUT_EMPTY_VAL;
    res.range_empty = 1'b0;
    if (int'(rq.row) >= r_hi || int'(rq.col) >= c_hi) begin
      res.range_empty = 1'b1;
    end else begin
      for (int r = int'(rq.row); r < r_hi; r++) begin
        for (int c = int'(rq.col); c < c_hi; c++) begin
          if (cell_grid[r][c] > best) best = cell_grid[r][c];
        end
      end
    end
    res.max_value = best;
    return res;
  endfunction

  always @(posedge clk) begin : sample
    rect_req_t    rq;
    rect_result_t want;
    if (!rst_n) begin
      for (int r = 0; r < ROWS_DEF; r++) begin
        for (int c = 0; c < COLS_DEF; c++) cell_grid[r][c] = OUT_EMPTY_VAL;
      end
      expected_maxima.delete();
    end else begin
      // results first: nothing accepted in this cycle can already have its answer out
      if (out_tvalid && out_tready) begin
        if (expected_maxima.size() == 0) begin
          report_mismatch($sformatf("unexpected result max=%h empty=%b", out_tdata, out_tuser));
        end else begin
          want = expected_maxima.pop_front();
          if (out_tdata !== want.max_value)
            report_mismatch($sformatf("max_value got %h want %h", out_tdata, want.max_value));
          if (out_tuser !== want.range_empty)
            report_mismatch($sformatf("range_empty got %b want %b", out_tuser,
                                      want.range_empty));
        end
      end
      if (in_tvalid && in_tready) begin
        rq = in_tdata;
        if (in_tuser == REQ_QUERY) expected_maxima.push_back(predict_rect_max(rq));
        else cell_grid[rq.row][rq.col] = rq.value;
      end
    end
    pending_count = expected_maxima.size();
  end

endmodule

[test/tb_top.sv]
// Top of the 2-D range-max tree bench: clock, reset, stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rm2d_pkg::*;

  localparam int PAD_W        = IN_DATA_W - ROW_W - COL_W - 2 * END_W - IN_VAL_W;
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off under pressure
  localparam int STALL_LIMIT  = 5000;  // cycles without any transfer; covers the clearing pass
  localparam int DRAIN_CYCLES = 200;   // a bit above the slowest query plus an update

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int error_count;
  int pending_count;
  int idle_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;
  logic hold_req;

  range_max_2d_segment_tree u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rm2d_query_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random at each falling edge, or hold off for a long stretch on
  // request so that a result sits in the block and the request side backs up.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one request: idle at random first, then hold it until the transfer
  task automatic send_req(input logic kind, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [END_W-1:0] row_end,
                          input logic [END_W-1:0] col_end, input logic [IN_VAL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{PAD_W{1'b0}}, value, col_end, row_end, col, row};
    do @(posedge clk); while (!in_tready);
  endtask

  // Cell values: mostly random, with extremes and a cluster near zero to force ties
  function automatic logic [IN_VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3, 4:    return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed rectangles; the rest carry raw 5-bit bounds (clamped, empty, inverted)
  task automatic send_random_req();
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [END_W-1:0] re;
    logic [END_W-1:0] ce;
    int               pick;
    pick = $urandom_range(99);
    r    = ROW_W'($urandom_range(ROWS_DEF - 1));
    c    = COL_W'($urandom_range(COLS_DEF - 1));
    re   = END_W'($urandom);
    ce   = END_W'($urandom);
    if (pick < 45) begin
      send_req(REQ_UPDATE, r, c, re, ce, random_value());
    end else begin
      if (pick < 88) begin
        re = END_W'($urandom_range(ROWS_DEF, r + 1));
        ce = END_W'($urandom_range(COLS_DEF, c + 1));
      end
      send_req(REQ_QUERY, r, c, re, ce, $urandom);
    end
  endtask

  initial begin
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    in_tuser           = REQ_UPDATE;
    hold_req           = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    idle_cycles        = 0;
    rst_n              = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fresh store, corners, extremes, clamped/empty/inverted rectangles
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd16, 5'd16, 32'h0);        // never-written cells
    send_req(REQ_QUERY,  4'd3,  4'd3,  5'd3,  5'd9,  32'h0);        // zero-height rectangle
    send_req(REQ_UPDATE, 4'd0,  4'd0,  5'd31, 5'd31, 32'h7fff_ffff);// ignored bounds set
    send_req(REQ_UPDATE, 4'd15, 4'd15, 5'd0,  5'd0,  32'h8000_0000);
    send_req(REQ_UPDATE, 4'd0,  4'd15, 5'd5,  5'd7,  32'hffff_ffff);
    send_req(REQ_UPDATE, 4'd15, 4'd0,  5'd16, 5'd1,  32'h0);
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd16, 5'd16, 32'hffff_ffff);
    send_req(REQ_QUERY,  4'd1,  4'd0,  5'd16, 5'd16, 32'h0);
    send_req(REQ_QUERY,  4'd15, 4'd15, 5'd31, 5'd31, 32'h0);        // bounds past the grid
    send_req(REQ_QUERY,  4'd10, 4'd2,  5'd4,  5'd16, 32'h0);        // inverted rows
    send_req(REQ_QUERY,  4'd0,  4'd5,  5'd16, 5'd5,  32'h0);        // zero-width
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd0,  5'd16, 32'h0);
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd16, 5'd0,  32'h0);
    send_req(REQ_QUERY,  4'd0,  4'd15, 5'd1,  5'd16, 32'h0);        // single cell
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd17, 5'd31, 32'h0);
    send_req(REQ_UPDATE, 4'd7,  4'd8,  5'd0,  5'd0,  32'h1234_5678);
    send_req(REQ_QUERY,  4'd7,  4'd8,  5'd8,  5'd9,  32'h0);
    send_req(REQ_UPDATE, 4'd0,  4'd0,  5'd0,  5'd0,  32'hffff_fffb);// overwrite the max
    send_req(REQ_QUERY,  4'd0,  4'd0,  5'd16, 5'd16, 32'h0);
    send_req(REQ_QUERY,  4'd15, 4'd15, 5'd16, 5'd16, 32'h0);
    send_req(REQ_QUERY,  4'd8,  4'd7,  5'd31, 5'd9,  32'h0);

    // Random: back to back, then sender gaps, then receiver stalls, then both
    repeat (240) send_random_req();
    sender_idle_pct = 74;
    repeat (240) send_random_req();
    sender_idle_pct    = 0;
    receiver_stall_pct = 74;
    repeat (240) send_random_req();
    sender_idle_pct    = 35;
    receiver_stall_pct = 35;
    hold_req           = 1'b1;  // keep offering while the receiver holds off
    repeat (230) send_random_req();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rm2d_pkg.sv
hw/rtl/rm2d_ram.sv
hw/rtl/rm2d_seq.sv
hw/rtl/range_max_2d_segment_tree.sv
test/rm2d_query_checker.sv
test/tb_top.sv
